// File: design/stereo_biquad_filter_assert.svh
// Assertion macros used by the stereo biquad filter checker.
`ifndef STEREO_BIQUAD_FILTER_ASSERT_SVH
`define STEREO_BIQUAD_FILTER_ASSERT_SVH

// Same-cycle implication: when pre holds at an edge, post holds at that edge.
`define SBQ_ASSERT_SAME(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// Next-cycle implication: when pre holds at an edge, post holds at the next one.
`define SBQ_ASSERT_NEXT(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

// File: design/sbq_pkg.sv
// Shared constants of the stereo biquad filter.
package sbq_pkg;

   localparam int COEF_WIDTH       = 16;
   localparam int FRAC_BITS_DEF    = 14;
   localparam int SAMPLE_WIDTH_DEF = 16;
   localparam int NUM_CHANNELS_DEF = 2;
   localparam int CSR_INDEX_WIDTH  = 3;

   // Configuration register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_COEF_B0       = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_COEF_B1       = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_COEF_B2       = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_COEF_A1       = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_COEF_A2       = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_STEREO_ENABLE = 3'd5;

   // Channel codes
   localparam logic CH_LEFT  = 1'b0;
   localparam logic CH_RIGHT = 1'b1;

endpackage

// File: design/stereo_biquad_filter.sv
// Stereo direct-form-I biquad filter with per-channel history in a small memory.
//
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  request | req_valid/req_ready, req_channel,       | in
//          | req_sample_in                           |
//  result  | rsp_valid/rsp_ready, rsp_sample_out,    | out
//          | rsp_out_channel                         |
//  config  | csr_write_en, csr_index, csr_wdata      | in
//
// One transaction per cycle sustained while the output does not stall. An accepted
// transaction is registered in the compute stage, then in the output register that
// drives rsp_valid. The rate is set by the history read-modify-write: the history
// memory is read at acceptance and written back as the compute stage advances, with
// a one-entry forward register covering a same-channel transaction that follows
// directly. The five multipliers and the accumulator sum sit in the compute stage.
// Reset is synchronous and clears history valid bits and control state at once.
// A stalled result holds in the output register; one more transaction is taken.
module stereo_biquad_filter #(
   parameter int FRAC_BITS    = sbq_pkg::FRAC_BITS_DEF,
   parameter int SAMPLE_WIDTH = sbq_pkg::SAMPLE_WIDTH_DEF,
   parameter int NUM_CHANNELS = sbq_pkg::NUM_CHANNELS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_channel,
   input  logic signed [SAMPLE_WIDTH-1:0]       req_sample_in,
   // result channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [SAMPLE_WIDTH-1:0]       rsp_sample_out,
   output logic                                 rsp_out_channel,
   // configuration port
   input  logic                                 csr_write_en,
   input  logic [sbq_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [sbq_pkg::COEF_WIDTH-1:0]       csr_wdata
);

   localparam int CW      = sbq_pkg::COEF_WIDTH;
   localparam int SW      = SAMPLE_WIDTH;
   localparam int ADDR_W  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int HIST_W  = 4 * SW;
   localparam int ACC_A   = SW + CW + 3;
   localparam int ACC_B   = FRAC_BITS + 2;
   localparam int ACC_W   = (ACC_A > ACC_B) ? ACC_A : ACC_B;
   localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (FRAC_BITS - 1);
   localparam logic signed [SW-1:0]    SAT_MAX    = {1'b0, {(SW-1){1'b1}}};
   localparam logic signed [SW-1:0]    SAT_MIN    = {1'b1, {(SW-1){1'b0}}};

   // configuration registers
   logic signed [CW-1:0] coef_b0_ff, coef_b1_ff, coef_b2_ff, coef_a1_ff, coef_a2_ff;
   logic                 stereo_en_ff;

   // history memory, one word {y2, y1, x2, x1} per channel
   logic [HIST_W-1:0]       hist_mem [NUM_CHANNELS];
   logic [NUM_CHANNELS-1:0] hist_live_ff;
   logic [HIST_W-1:0]       rd_data_ff;
   logic                    rd_live_ff;

   // forward register: the most recent history write
   logic              fwd_valid_ff;
   logic [ADDR_W-1:0] fwd_addr_ff;
   logic [HIST_W-1:0] fwd_data_ff;

   // compute stage
   logic                 b_valid_ff, b_valid_in;
   logic                 b_filter_ff;
   logic                 b_channel_ff;
   logic [ADDR_W-1:0]    b_addr_ff;
   logic signed [SW-1:0] b_sample_ff;

   // output register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic signed [SW-1:0] rsp_sample_ff;
   logic                 rsp_channel_ff;

   logic                 req_accept;
   logic                 out_advance;
   logic                 b_advance;
   logic                 hist_wr_en;
   logic [ADDR_W-1:0]    req_addr;
   logic                 req_filter;
   logic [HIST_W-1:0]    hist_cur;
   logic [HIST_W-1:0]    hist_new;
   logic signed [SW-1:0] x1, x2, y1, y2;
   logic signed [ACC_W-1:0] prod_b0, prod_b1, prod_b2, prod_a1, prod_a2;
   logic signed [ACC_W-1:0] acc, acc_shift;
   logic [ACC_W-SW:0]       acc_top;
   logic signed [SW-1:0]    y_sat, y_out;

   // handshake: the output register parts the two sides
   assign out_advance = !rsp_valid_ff || rsp_ready;
   assign b_advance   = b_valid_ff && out_advance;
   assign req_ready   = !b_valid_ff || out_advance;
   assign req_accept  = req_valid && req_ready;

   assign req_addr   = ADDR_W'((NUM_CHANNELS > 1) ? req_channel : sbq_pkg::CH_LEFT);
   assign req_filter = (req_channel == sbq_pkg::CH_LEFT) ||
                       (stereo_en_ff && (NUM_CHANNELS > 1));

   // write configuration registers; ignore unknown indexes
   always_ff @(posedge clock) begin
      if (reset) begin
         coef_b0_ff   <= '0;
         coef_b1_ff   <= '0;
         coef_b2_ff   <= '0;
         coef_a1_ff   <= '0;
         coef_a2_ff   <= '0;
         stereo_en_ff <= 1'b0;
      end else if (csr_write_en) begin
         unique case (csr_index)
            sbq_pkg::REG_COEF_B0:       coef_b0_ff   <= csr_wdata;
            sbq_pkg::REG_COEF_B1:       coef_b1_ff   <= csr_wdata;
            sbq_pkg::REG_COEF_B2:       coef_b2_ff   <= csr_wdata;
            sbq_pkg::REG_COEF_A1:       coef_a1_ff   <= csr_wdata;
            sbq_pkg::REG_COEF_A2:       coef_a2_ff   <= csr_wdata;
            sbq_pkg::REG_STEREO_ENABLE: stereo_en_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // read history at acceptance, write back from the compute stage
   always_ff @(posedge clock) begin
      if (req_accept) begin
         rd_data_ff <= hist_mem[req_addr];
      end
      if (hist_wr_en) begin
         hist_mem[b_addr_ff] <= hist_new;
      end
   end

   // track which entries hold written history and the latest write
   always_ff @(posedge clock) begin
      if (reset) begin
         hist_live_ff <= '0;
         fwd_valid_ff <= 1'b0;
      end else begin
         if (req_accept) begin
            rd_live_ff <= hist_live_ff[req_addr];
         end
         if (hist_wr_en) begin
            hist_live_ff[b_addr_ff] <= 1'b1;
            fwd_valid_ff            <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (hist_wr_en) begin
         fwd_addr_ff <= b_addr_ff;
         fwd_data_ff <= hist_new;
      end
   end

   // advance the compute stage
   always_comb begin
      b_valid_in = b_valid_ff;
      if (req_accept) begin
         b_valid_in = 1'b1;
      end else if (b_advance) begin
         b_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         b_filter_ff  <= req_filter;
         b_channel_ff <= req_channel;
         b_addr_ff    <= req_addr;
         b_sample_ff  <= req_sample_in;
      end
   end

   // select history: forwarded write, stored word, or zero before first write
   always_comb begin
      if (fwd_valid_ff && (fwd_addr_ff == b_addr_ff)) begin
         hist_cur = fwd_data_ff;
      end else if (rd_live_ff) begin
         hist_cur = rd_data_ff;
      end else begin
         hist_cur = '0;
      end
   end

   assign x1 = hist_cur[SW-1:0];
   assign x2 = hist_cur[2*SW-1:SW];
   assign y1 = hist_cur[3*SW-1:2*SW];
   assign y2 = hist_cur[4*SW-1:3*SW];

   // multiply-accumulate, round half up, shift
   assign prod_b0 = ACC_W'(coef_b0_ff) * ACC_W'(b_sample_ff);
   assign prod_b1 = ACC_W'(coef_b1_ff) * ACC_W'(x1);
   assign prod_b2 = ACC_W'(coef_b2_ff) * ACC_W'(x2);
   assign prod_a1 = ACC_W'(coef_a1_ff) * ACC_W'(y1);
   assign prod_a2 = ACC_W'(coef_a2_ff) * ACC_W'(y2);

   assign acc       = prod_b0 + prod_b1 + prod_b2 - prod_a1 - prod_a2 + ROUND_HALF;
   assign acc_shift = acc >>> FRAC_BITS;

   // saturate to the sample range
   assign acc_top = acc_shift[ACC_W-1:SW-1];
   always_comb begin
      if ((&acc_top) || !(|acc_top)) begin
         y_sat = acc_shift[SW-1:0];
      end else if (acc_shift[ACC_W-1]) begin
         y_sat = SAT_MIN;
      end else begin
         y_sat = SAT_MAX;
      end
   end

   assign y_out      = b_filter_ff ? y_sat : b_sample_ff;
   assign hist_new   = {y1, y_sat, x1, b_sample_ff};
   assign hist_wr_en = b_advance && b_filter_ff;

   // load the output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (b_advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (b_advance) begin
         rsp_sample_ff  <= y_out;
         rsp_channel_ff <= b_channel_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_sample_out  = rsp_sample_ff;
   assign rsp_out_channel = rsp_channel_ff;

endmodule

// File: design/sbq_checker.sv
// Port-level checker for the stereo biquad filter, bound to the top level.
`include "stereo_biquad_filter_assert.svh"

module sbq_checker #(
   parameter int SAMPLE_WIDTH = sbq_pkg::SAMPLE_WIDTH_DEF
) (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_ready,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input logic [SAMPLE_WIDTH-1:0] rsp_sample_out,
   input logic                    rsp_out_channel
);

   // a stalled result keeps its payload
   `SBQ_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_sample_out) && $stable(rsp_out_channel), "result changed while stalled")

   // reset empties the output
   `SBQ_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid, "result valid after reset")

   // every accepted transaction leaves a result pending after the compute stage and output register
   `SBQ_ASSERT_NEXT(a_latency, clock, reset, req_valid && req_ready, ##1 rsp_valid, "no result two cycles after acceptance")

   // a fresh result follows an acceptance through the compute stage and output register
   `SBQ_ASSERT_SAME(a_no_invent, clock, reset, $rose(rsp_valid), $past(req_valid && req_ready, 2), "result without a transaction")

endmodule

bind stereo_biquad_filter sbq_checker #(
   .SAMPLE_WIDTH(SAMPLE_WIDTH)
) u_sbq_checker (.*);
